FILE: sv/dik_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dik_pkg
// shared widths, register indexes and command/status types
// ----------------------------------------------------------------------------
package dik_pkg;
  localparam int PosW   = 32;
  localparam int CfgW   = 64;
  localparam int IdxW   = 3;
  localparam int MagW   = 33;            // |a - b| of two 32-bit values
  localparam int SqW    = 66;            // square of a magnitude
  localparam int RadW   = 64;            // radicand width, even
  localparam int RootW  = RadW / 2;
  localparam int HalfW  = 17;            // multiplier operand half width
  localparam int SqStepW = 3;

  typedef enum logic [IdxW-1:0] {
    REG_T0_XY = 3'd0,
    REG_T1_XY = 3'd1,
    REG_T2_XY = 3'd2,
    REG_T0_HR = 3'd3,
    REG_T1_HR = 3'd4,
    REG_T2_HR = 3'd5
  } reg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic       load;      // latch target, select tower 0
    logic       setup;     // form magnitudes of current tower
    logic       sq_step;   // one partial product step
    logic       rad;       // form radicand and reach flag
    logic       root_init;
    logic       root_step;
    logic       finish;    // final add and saturate, next tower
    logic [1:0] tower;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sq_done;
    logic root_done;
  } dp_sts_t;
endpackage
`default_nettype wire

FILE: sv/dik_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dik_target_if / dik_motor_if
// valid/ready channels for target points and carriage results
// ----------------------------------------------------------------------------
interface dik_target_if;
  import dik_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] target_x;
  logic signed [PosW-1:0] target_y;
  logic signed [PosW-1:0] target_z;
  logic                   x_present;
  logic                   y_present;
  logic                   z_present;
  modport source (output valid, target_x, target_y, target_z, x_present, y_present,
                  z_present, input ready);
  modport sink   (input valid, target_x, target_y, target_z, x_present, y_present,
                  z_present, output ready);
endinterface

interface dik_motor_if;
  import dik_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] motor0_pos;
  logic signed [PosW-1:0] motor1_pos;
  logic signed [PosW-1:0] motor2_pos;
  logic [2:0]             reach_error;
  modport source (output valid, motor0_pos, motor1_pos, motor2_pos, reach_error,
                  input ready);
  modport sink   (input valid, motor0_pos, motor1_pos, motor2_pos, reach_error,
                  output ready);
endinterface
`default_nettype wire

FILE: sv/dik_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dik_datapath
// config registers, last position, shared squarer and iterative root
// ----------------------------------------------------------------------------
module dik_datapath import dik_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [IdxW-1:0]        cfg_idx_i,
  input  wire logic [CfgW-1:0]        cfg_data_i,
  input  wire logic signed [PosW-1:0] tx_i,
  input  wire logic signed [PosW-1:0] ty_i,
  input  wire logic signed [PosW-1:0] tz_i,
  input  wire logic [2:0]             pres_i,
  input  wire dp_cmd_t                cmd_i,
  output dp_sts_t                     sts_o,
  output logic signed [PosW-1:0]      m0_o,
  output logic signed [PosW-1:0]      m1_o,
  output logic signed [PosW-1:0]      m2_o,
  output logic [2:0]                  err_o
);
  logic [CfgW-1:0] xy_q [3];
  logic [CfgW-1:0] hr_q [3];
  logic signed [PosW-1:0] lx_q, ly_q, lz_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        xy_q[i] <= '0;
        hr_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_T0_XY: xy_q[0] <= cfg_data_i;
        REG_T1_XY: xy_q[1] <= cfg_data_i;
        REG_T2_XY: xy_q[2] <= cfg_data_i;
        REG_T0_HR: hr_q[0] <= cfg_data_i;
        REG_T1_HR: hr_q[1] <= cfg_data_i;
        REG_T2_HR: hr_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // last applied position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= '0; ly_q <= '0; lz_q <= '0;
    end else if (cmd_i.load) begin
      if (pres_i[0]) lx_q <= tx_i;
      if (pres_i[1]) ly_q <= ty_i;
      if (pres_i[2]) lz_q <= tz_i;
    end
  end

  // tower select and magnitudes
  logic signed [PosW-1:0] bx, by, bh, rod_s;
  assign bx    = xy_q[cmd_i.tower][63:32];
  assign by    = xy_q[cmd_i.tower][31:0];
  assign bh    = hr_q[cmd_i.tower][63:32];
  assign rod_s = hr_q[cmd_i.tower][31:0];

  function automatic logic [MagW-1:0] magdiff(logic signed [PosW-1:0] a,
                                              logic signed [PosW-1:0] b);
    logic [MagW-1:0] d;
    d = {a[PosW-1], a} - {b[PosW-1], b};
    magdiff = d[MagW-1] ? MagW'(-d) : MagW'(d);
  endfunction

  logic [MagW-1:0] ax_q, ay_q, rod_q;
  logic signed [PosW:0] zoff_q;
  logic [SqW-1:0] acc_q [3];
  logic [SqStepW-1:0] sq_cnt_q;

  // squarer: 4 half-width partial products per operand, 3 operands in lanes
  logic [HalfW-1:0] a_lo [3], a_hi [3];
  logic [MagW-1:0] opnd [3];
  assign opnd[0] = ax_q;
  assign opnd[1] = ay_q;
  assign opnd[2] = rod_q;
  logic [2*HalfW-1:0] pp [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_lo[k] = {1'b0, opnd[k][15:0]};
      a_hi[k] = opnd[k][32:16];
      unique case (sq_cnt_q[1:0])
        2'd0:    pp[k] = a_lo[k] * a_lo[k];
        2'd1:    pp[k] = a_lo[k] * a_hi[k];
        2'd2:    pp[k] = a_hi[k] * a_lo[k];
        default: pp[k] = a_hi[k] * a_hi[k];
      endcase
    end
  end
  logic [SqW-1:0] pp_q [3];
  logic [SqStepW-1:0] pp_cnt_q;
  logic pp_v_q;

  // root unit
  logic [RadW-1:0] rem_q, res_q, bit_q;
  logic [2:0] err_q;
  logic signed [PosW-1:0] m_q [3];

  assign sts_o.sq_done   = (pp_cnt_q == 3'd3) && pp_v_q;
  assign sts_o.root_done = (bit_q == '0);

  logic [SqW-1:0] l2, r2;
  assign l2 = acc_q[2];
  assign r2 = acc_q[0] + acc_q[1];

  logic [RadW-1:0] rb;
  assign rb = res_q + bit_q;

  logic [RootW:0] root_r;
  assign root_r = (rem_q > res_q) ? (RootW+1)'(res_q) + 1'b1 : (RootW+1)'(res_q);
  logic signed [PosW+2:0] pos;
  assign pos = $signed({2'b00, root_r}) + (PosW+3)'(zoff_q);
  logic signed [PosW-1:0] sat;
  always_comb begin
    if (pos > $signed((PosW+3)'({1'b0, {(PosW-1){1'b1}}})))
      sat = {1'b0, {(PosW-1){1'b1}}};
    else if (pos < -$signed((PosW+3)'({1'b1, {(PosW-1){1'b0}}})))
      sat = {1'b1, {(PosW-1){1'b0}}};
    else
      sat = pos[PosW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q <= '0; pp_cnt_q <= '0; pp_v_q <= 1'b0;
      err_q <= '0; bit_q <= '0;
      ax_q <= '0; ay_q <= '0; rod_q <= '0; zoff_q <= '0;
      rem_q <= '0; res_q <= '0;
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= '0;
        pp_q[k]  <= '0;
        m_q[k]   <= '0;
      end
    end else begin
      pp_v_q <= cmd_i.sq_step;
      if (cmd_i.load) err_q <= '0;
      if (cmd_i.setup) begin
        ax_q   <= magdiff(lx_q, bx);
        ay_q   <= magdiff(ly_q, by);
        rod_q  <= rod_s[PosW-1] ? MagW'(-{rod_s[PosW-1], rod_s}) : MagW'(rod_s);
        zoff_q <= {lz_q[PosW-1], lz_q} - {bh[PosW-1], bh};
        sq_cnt_q <= '0;
        for (int k = 0; k < 3; k++) acc_q[k] <= '0;
      end
      if (cmd_i.sq_step) begin
        sq_cnt_q <= sq_cnt_q + 1'b1;
        pp_cnt_q <= sq_cnt_q;
        for (int k = 0; k < 3; k++) begin
          unique case (sq_cnt_q[1:0])
            2'd0:    pp_q[k] <= SqW'(pp[k]);
            2'd1,
            2'd2:    pp_q[k] <= SqW'(pp[k]) << 16;
            default: pp_q[k] <= SqW'(pp[k]) << 32;
          endcase
        end
      end
      if (pp_v_q) begin
        for (int k = 0; k < 3; k++) acc_q[k] <= acc_q[k] + pp_q[k];
      end
      if (cmd_i.rad) begin
        if (r2 > l2) begin
          err_q[cmd_i.tower] <= 1'b1;
          rem_q <= '0;
        end else begin
          rem_q <= RadW'(l2 - r2);
        end
      end
      if (cmd_i.root_init) begin
        res_q <= '0;
        bit_q <= {2'b01, {(RadW-2){1'b0}}};
      end
      if (cmd_i.root_step) begin
        if (rem_q >= rb) begin
          rem_q <= rem_q - rb;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      if (cmd_i.finish) m_q[cmd_i.tower] <= err_q[cmd_i.tower] ? '0 : sat;
    end
  end

  assign m0_o  = m_q[0];
  assign m1_o  = m_q[1];
  assign m2_o  = m_q[2];
  assign err_o = err_q;
endmodule
`default_nettype wire

FILE: sv/dik_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dik_ctrl
// sequencer over three towers: setup, square, radicand, root, finish
// ----------------------------------------------------------------------------
module dik_ctrl import dik_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SETUP = 8'b0000_0010,
    S_SQ    = 8'b0000_0100,
    S_RAD   = 8'b0000_1000,
    S_RINIT = 8'b0001_0000,
    S_ROOT  = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] tower_q, tower_d;
  logic [2:0] step_q, step_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  // next state and commands
  always_comb begin
    state_d = state_q;
    tower_d = tower_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.tower = tower_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          tower_d = 2'd0;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        step_d  = '0;
        state_d = S_SQ;
      end
      S_SQ: begin
        if (step_q < 3'd4) begin
          cmd_o.sq_step = 1'b1;
          step_d = step_q + 1'b1;
        end
        if (sts_i.sq_done) state_d = S_RAD;
      end
      S_RAD: begin
        cmd_o.rad = 1'b1;
        state_d = S_RINIT;
      end
      S_RINIT: begin
        cmd_o.root_init = 1'b1;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (sts_i.root_done) state_d = S_FIN;
        else cmd_o.root_step = 1'b1;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        if (tower_q == 2'd2) begin
          state_d = S_OUT;
        end else begin
          tower_d = tower_q + 1'b1;
          state_d = S_SETUP;
        end
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tower_q <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      tower_q <= tower_d;
      step_q  <= step_d;
    end
  end
endmodule
`default_nettype wire

FILE: sv/delta_inverse_kinematics.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delta_inverse_kinematics
// carriage heights of a linear delta for one target point
// ----------------------------------------------------------------------------
// channel   dir  payload
// tgt       in   target_x/y/z, x/y/z_present
// mot       out  motor0..2_pos, reach_error
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (six 64-bit tower registers)
//
// per item: an accept step, then per tower a setup, the squarer (4 partial
// products, then a drain), radicand and root init, the root (32 bit steps of
// the shared root unit, then a done check) and finish; then a result step.
// one item at a time; the result holds until taken, then a new item is taken.
// reset clears registers, last position and the sequencer.
module delta_inverse_kinematics import dik_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [IdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  dik_target_if.sink           tgt,
  dik_motor_if.source          mot
);
  dp_cmd_t cmd;
  dp_sts_t sts;

  dik_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (tgt.valid),
    .in_ready_o (tgt.ready),
    .out_valid_o(mot.valid),
    .out_ready_i(mot.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dik_datapath u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .tx_i  (tgt.target_x),
    .ty_i  (tgt.target_y),
    .tz_i  (tgt.target_z),
    .pres_i({tgt.z_present, tgt.y_present, tgt.x_present}),
    .cmd_i (cmd),
    .sts_o (sts),
    .m0_o  (mot.motor0_pos),
    .m1_o  (mot.motor1_pos),
    .m2_o  (mot.motor2_pos),
    .err_o (mot.reach_error)
  );
endmodule
`default_nettype wire

FILE: sv/dik_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dik_checker
// port-level checks on the target and result channels
// ----------------------------------------------------------------------------
module dik_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] m0,
  input wire logic [2:0]  err
);
  // never both sides active at once: one item in flight
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("ready while result pending");
  // accepted item leaves no result the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");
  // reach error forces zero motor
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && err[0]) |-> (m0 == '0)) else $error("motor0 not zero");
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(m0) && $stable(err)))
    else $error("result changed under stall");
endmodule

bind delta_inverse_kinematics dik_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid (tgt.valid), .in_ready (tgt.ready),
  .out_valid(mot.valid), .out_ready(mot.ready),
  .m0(mot.motor0_pos), .err(mot.reach_error)
);
`default_nettype wire
